### rtl/posit32_double_converter_unit_defines.svh
// Assertion macros for the posit/double converter
`ifndef POSIT32_DOUBLE_CONVERTER_UNIT_DEFINES_SVH
`define POSIT32_DOUBLE_CONVERTER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// checked only outside reset
`define P32DC_ASSERT(lbl, clk_i, rst_ni, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define P32DC_ASSERT_ALWAYS(lbl, clk_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define P32DC_ASSERT(lbl, clk_i, rst_ni, prop, msg)
`define P32DC_ASSERT_ALWAYS(lbl, clk_i, prop, msg)

`endif

`endif

### rtl/p32dc_pkg.sv
package p32dc_pkg;

	typedef struct packed {
		logic        mode;
		logic [63:0] operand;
	} req_t;

	typedef struct packed {
		logic [63:0] result;
		logic        invalid;
	} rsp_t;

	typedef logic [4:0] run_t;

	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	localparam logic [1:0]  ES_RESET     = 2'd2;
	localparam logic [10:0] EXP_ALL_ONES = 11'h7ff;
	localparam logic [11:0] EXP_BIAS     = 12'd1023;
	localparam logic [31:0] POSIT_NAR    = 32'h8000_0000;
	localparam logic [30:0] POSIT_MAXPOS = 31'h7fff_ffff;
	localparam logic [63:0] DBL_POS_INF  = 64'h7ff0_0000_0000_0000;

endpackage

### rtl/posit32_double_converter_unit.sv
// channel | direction | payload                  | handshake
// req     | in        | mode, operand            | req_valid / req_ready
// rsp     | out       | result, invalid          | rsp_valid / rsp_ready
// cfg     | in        | posit_es (cfg_wdata)     | cfg_we, no wait
//
// Four register stages; one transaction per cycle unless rsp_ready stalls the pipe.
// Stage depth is set by the 64-bit regime shifter, the 31-bit rounding increment
// and the regime run count.
// Reset clears all stage valids and sets posit_es to 2.
// A full stage holds while the next one is full and cannot advance; empty stages are filled under a stall.
`include "posit32_double_converter_unit_defines.svh"

module posit32_double_converter_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  p32dc_pkg::req_t     req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output p32dc_pkg::rsp_t     rsp,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_wdata
);

	logic [1:0] es_q;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	// stage 1 signals
	logic [10:0]        bexp_c;
	logic [51:0]        mant_c;
	logic [31:0]        p_c;
	logic signed [11:0] e_c, maxe_c, mine_c, ecl_c;
	logic signed [8:0]  ec_c, reg9_c;
	logic signed [5:0]  reg_c;
	logic [5:0]         shx_c;
	logic [2:0]         emask_c, eb_c;
	logic               rpos_c;
	logic [61:0]        pay_c;
	logic               nar_c, zero_c, inv_c, sgn_c;

	logic               mode_s1, sgn_s1, zero_s1, nar_s1, inv_s1, rpos_s1;
	logic [1:0]         es_s1;
	logic [4:0]         sh_s1;
	logic [61:0]        pay_s1;
	logic [31:0]        pos_s1;

	// stage 2 signals
	logic [63:0]        frac_c;
	logic [30:0]        rv_c;
	p32dc_pkg::run_t    k_c;

	logic               mode_s2, sgn_s2, zero_s2, nar_s2, inv_s2, stk_s2;
	logic [1:0]         es_s2;
	logic [31:0]        hi_s2;
	logic [31:0]        pos_s2;
	p32dc_pkg::run_t    k_s2;

	// stage 3 signals
	logic               rnd_c;
	logic [31:0]        sum_c;
	logic [30:0]        mag_c;
	logic signed [6:0]  sr_c;
	logic [5:0]         pamt_c;
	logic [31:0]        pef_c, pfrac_c;
	logic [2:0]         efield_c;
	logic [11:0]        de_c;
	logic [63:0]        dres_c;

	logic               mode_s3, sgn_s3, zero_s3, nar_s3, inv_s3;
	logic [30:0]        mag_s3;
	logic [63:0]        dres_s3;

	// stage 4 signals
	logic [31:0]        emag_c;
	logic [63:0]        res_c;

	logic               mode_s4, inv_s4;
	logic [63:0]        res_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			es_q <= p32dc_pkg::ES_RESET;
		end else if (cfg_we) begin
			es_q <= cfg_wdata;
		end
	end

	assign en_s4     = !v_s4 || rsp_ready;
	assign en_s3     = !v_s3 || en_s4;
	assign en_s2     = !v_s2 || en_s3;
	assign en_s1     = !v_s1 || en_s2;
	assign req_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= req_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// stage 1: classify, clamp the exponent, split regime and exponent bits
	always_comb begin
		bexp_c  = req.operand[62:52];
		mant_c  = req.operand[51:0];
		p_c     = req.operand[31:0];
		e_c     = $signed({1'b0, bexp_c}) - $signed(p32dc_pkg::EXP_BIAS);
		maxe_c  = $signed(12'd30 << es_q);
		mine_c  = 12'sd0 - $signed(12'd31 << es_q);
		if (e_c > maxe_c) begin
			ecl_c = maxe_c;
		end else if (e_c < mine_c) begin
			ecl_c = mine_c;
		end else begin
			ecl_c = e_c;
		end
		ec_c    = ecl_c[8:0];
		reg9_c  = ec_c >>> es_q;
		reg_c   = reg9_c[5:0];
		emask_c = 3'b111 >> (2'd3 - es_q);
		eb_c    = ec_c[2:0] & emask_c;
		rpos_c  = !reg_c[5];
		shx_c   = rpos_c ? (reg_c + 6'd1) : (6'd0 - reg_c);
		pay_c   = ({mant_c, 10'b0} >> es_q) | (62'(eb_c) << (6'd62 - {4'b0, es_q}));
		nar_c   = (bexp_c == p32dc_pkg::EXP_ALL_ONES);
		inv_c   = nar_c && (mant_c != 52'd0);
		zero_c  = (bexp_c == 11'd0) && (mant_c == 52'd0);
		sgn_c   = (req.mode == p32dc_pkg::MODE_DECODE) ? p_c[31] : req.operand[63];
	end

	always_ff @(posedge clk) begin
		if (en_s1 && req_valid) begin
			mode_s1 <= req.mode;
			es_s1   <= es_q;
			sgn_s1  <= sgn_c;
			rpos_s1 <= rpos_c;
			sh_s1   <= shx_c[4:0];
			pay_s1  <= pay_c;
			pos_s1  <= p_c[31] ? (32'd0 - p_c) : p_c;
			if (req.mode == p32dc_pkg::MODE_DECODE) begin
				zero_s1 <= (p_c == 32'd0);
				nar_s1  <= (p_c == p32dc_pkg::POSIT_NAR);
				inv_s1  <= 1'b0;
			end else begin
				zero_s1 <= zero_c;
				nar_s1  <= nar_c;
				inv_s1  <= inv_c;
			end
		end
	end

	// stage 2: place the regime run, count the run of a decoded posit
	assign frac_c = $signed({rpos_s1, !rpos_s1, pay_s1}) >>> sh_s1;
	assign rv_c   = pos_s1[30] ? ~pos_s1[30:0] : pos_s1[30:0];

	p32dc_run_cnt u_run_cnt (
		.bits  (rv_c),
		.count (k_c)
	);

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			mode_s2 <= mode_s1;
			es_s2   <= es_s1;
			sgn_s2  <= sgn_s1;
			zero_s2 <= zero_s1;
			nar_s2  <= nar_s1;
			inv_s2  <= inv_s1;
			hi_s2   <= frac_c[62:31];
			stk_s2  <= |frac_c[30:0];
			pos_s2  <= pos_s1;
			k_s2    <= k_c;
		end
	end

	// stage 3: round to nearest even with saturation; assemble the double
	always_comb begin
		rnd_c    = hi_s2[0] && (hi_s2[1] || stk_s2);
		sum_c    = {1'b0, hi_s2[31:1]} + {31'd0, rnd_c};
		if (sum_c[31]) begin
			mag_c = p32dc_pkg::POSIT_MAXPOS;
		end else if (sum_c[30:0] == 31'd0) begin
			mag_c = 31'd1;
		end else begin
			mag_c = sum_c[30:0];
		end
		sr_c     = pos_s2[30] ? ({2'b0, k_s2} - 7'd1) : (7'd0 - {2'b0, k_s2});
		pamt_c   = {1'b0, k_s2} + 6'd2;
		pef_c    = pos_s2 << pamt_c;
		efield_c = 3'(pef_c >> (6'd32 - {4'b0, es_s2}));
		pfrac_c  = pef_c << es_s2;
		de_c     = ({{5{sr_c[6]}}, sr_c} << es_s2) + {9'd0, efield_c} + p32dc_pkg::EXP_BIAS;
		if (zero_s2) begin
			dres_c = 64'd0;
		end else if (nar_s2) begin
			dres_c = p32dc_pkg::DBL_POS_INF;
		end else begin
			dres_c = {sgn_s2 | de_c[11], de_c[10:0], pfrac_c, 20'd0};
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			mode_s3 <= mode_s2;
			sgn_s3  <= sgn_s2;
			zero_s3 <= zero_s2;
			nar_s3  <= nar_s2;
			inv_s3  <= inv_s2;
			mag_s3  <= mag_c;
			dres_s3 <= dres_c;
		end
	end

	// stage 4: apply the sign, select the result
	always_comb begin
		emag_c = sgn_s3 ? (32'd0 - {1'b0, mag_s3}) : {1'b0, mag_s3};
		if (mode_s3 == p32dc_pkg::MODE_DECODE) begin
			res_c = dres_s3;
		end else if (zero_s3) begin
			res_c = 64'd0;
		end else if (nar_s3) begin
			res_c = {32'd0, p32dc_pkg::POSIT_NAR};
		end else begin
			res_c = {32'd0, emag_c};
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			mode_s4 <= mode_s3;
			inv_s4  <= inv_s3;
			res_s4  <= res_c;
		end
	end

	assign rsp_valid   = v_s4;
	assign rsp.result  = res_s4;
	assign rsp.invalid = inv_s4;

	`P32DC_ASSERT(a_inv_gives_nar, clk, arst_n, v_s4 && inv_s4 |-> res_s4 == {32'd0, p32dc_pkg::POSIT_NAR}, "invalid transaction without NaR result")
	`P32DC_ASSERT(a_decode_no_inv, clk, arst_n, v_s4 && (mode_s4 == p32dc_pkg::MODE_DECODE) |-> !inv_s4, "decode transaction flagged invalid")
	`P32DC_ASSERT(a_encode_upper_zero, clk, arst_n, v_s4 && (mode_s4 == p32dc_pkg::MODE_ENCODE) |-> res_s4[63:32] == 32'd0, "encode result has upper bits set")
	`P32DC_ASSERT_ALWAYS(a_full_when_blocked, clk, !req_ready |-> v_s1 && v_s2 && v_s3 && v_s4 && !rsp_ready, "input blocked with a free stage")

endmodule

### rtl/p32dc_run_cnt.sv
module p32dc_run_cnt (
	input  logic [30:0]       bits,
	output p32dc_pkg::run_t   count
);

	logic [31:0]      x;
	p32dc_pkg::run_t  n;

	// leading zeros of bits; sentinel caps the all-zero case at 31
	always_comb begin
		x = {bits, 1'b1};
		n = '0;
		if (x[31:16] == 16'd0) begin
			n[4] = 1'b1;
			x    = x << 16;
		end
		if (x[31:24] == 8'd0) begin
			n[3] = 1'b1;
			x    = x << 8;
		end
		if (x[31:28] == 4'd0) begin
			n[2] = 1'b1;
			x    = x << 4;
		end
		if (x[31:30] == 2'd0) begin
			n[1] = 1'b1;
			x    = x << 2;
		end
		if (x[31] == 1'b0) begin
			n[0] = 1'b1;
		end
	end

	assign count = n;

endmodule
